/* rtl/ppps_pkg.sv */
// Shared types, widths and codes for the polygon projection plane select unit.
// No dependencies; every other file of the unit imports this package.
package ppps_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int EDGE_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * EDGE_W;
	localparam int NORM_W      = PROD_W + 1;
	localparam int MAG_W       = NORM_W - 1;
	localparam int HALF_W      = (MAG_W + 1) / 2;
	localparam int HIGH_W      = MAG_W - HALF_W;
	localparam int MUL_W       = EDGE_W + 1;
	localparam int MULP_W      = 2 * MUL_W;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int QS_W        = SQ_W + 1;
	localparam int NUM_AXES    = 3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	typedef enum logic [1:0] {
		PLANE_XY   = 2'd0,
		PLANE_YZ   = 2'd1,
		PLANE_XZ   = 2'd2,
		PLANE_NONE = 2'd3
	} plane_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_EVAL,
		OP_CROSS_A,
		OP_CROSS_B,
		OP_CROSS_C,
		OP_SQ_MUL,
		OP_SQ_ACC,
		OP_SUM,
		OP_EMIT_PLANE,
		OP_EMIT_DEGEN
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CROSS_A,
		ST_CROSS_B,
		ST_CROSS_C,
		ST_DECIDE,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_SUM,
		ST_CMP
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic need_cross;
		logic last;
		logic normal_found;
		logic out_free;
	} sts_t;

endpackage

/* rtl/ppps_ifs.sv */
// Handshake channels of the unit: the vertex input and the plane result.
// Depends on ppps_pkg for the coordinate width.
interface ppps_vertex_if;
	import ppps_pkg::*;

	logic   valid;
	logic   ready;
	coord_t vertex_x;
	coord_t vertex_y;
	coord_t vertex_z;
	logic   last_vertex;

	modport source(output valid, output vertex_x, output vertex_y, output vertex_z,
		output last_vertex, input ready);
	modport sink(input valid, input vertex_x, input vertex_y, input vertex_z,
		input last_vertex, output ready);
endinterface

interface ppps_plane_if;
	logic       valid;
	logic       ready;
	logic [1:0] plane_choice;

	modport source(output valid, output plane_choice, input ready);
	modport sink(input valid, input plane_choice, output ready);
endinterface

/* rtl/ppps_ctrl.sv */
// Controller state machine: sequences load, cross product, squared norms and result.
// Depends on ppps_pkg; drives the datapath through cmd_t and reads sts_t.
module ppps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ppps_pkg::sts_t sts,
	output ppps_pkg::cmd_t cmd
);
	import ppps_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] comp_q, comp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			comp_q  <= '0;
		end else begin
			state_q <= state_d;
			comp_q  <= comp_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		comp_d   = comp_q;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.idx  = comp_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.op = OP_EVAL;
				if (sts.need_cross) begin
					state_d = ST_CROSS_A;
				end else if (sts.last) begin
					state_d = ST_DECIDE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CROSS_A: begin
				cmd.op  = OP_CROSS_A;
				state_d = ST_CROSS_B;
			end
			ST_CROSS_B: begin
				cmd.op  = OP_CROSS_B;
				state_d = ST_CROSS_C;
			end
			ST_CROSS_C: begin
				cmd.op  = OP_CROSS_C;
				state_d = sts.last ? ST_DECIDE : ST_IDLE;
			end
			ST_DECIDE: begin
				if (!sts.normal_found) begin
					if (sts.out_free) begin
						cmd.op  = OP_EMIT_DEGEN;
						state_d = ST_IDLE;
					end
				end else begin
					comp_d  = '0;
					state_d = ST_SQ_MUL;
				end
			end
			ST_SQ_MUL: begin
				cmd.op  = OP_SQ_MUL;
				state_d = ST_SQ_ACC;
			end
			ST_SQ_ACC: begin
				cmd.op = OP_SQ_ACC;
				if (comp_q == 2'(NUM_AXES - 1)) begin
					state_d = ST_SUM;
				end else begin
					comp_d  = comp_q + 2'd1;
					state_d = ST_SQ_MUL;
				end
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.out_free) begin
					cmd.op  = OP_EMIT_PLANE;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_comp_range: assert property (@(posedge clk) disable iff (!arst_n)
		comp_q != 2'd3)
		else $error("component counter out of range");

	a_sq_follows_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ_MUL |=> state_q == ST_SQ_ACC && $stable(comp_q))
		else $error("square accumulate did not follow multiply");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD |-> state_q == ST_IDLE && in_valid)
		else $error("vertex loaded outside idle");
`endif

endmodule

/* rtl/ppps_datapath.sv */
// Datapath: vertex registers, edges, three shared multipliers, normal, squared norms,
// plane compare and the result register. Depends on ppps_pkg; driven by ppps_ctrl.
module ppps_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  ppps_pkg::cmd_t   cmd,
	output ppps_pkg::sts_t   sts,
	input  ppps_pkg::coord_t vertex_x,
	input  ppps_pkg::coord_t vertex_y,
	input  ppps_pkg::coord_t vertex_z,
	input  logic             last_vertex,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [1:0]       plane_choice
);
	import ppps_pkg::*;

	function automatic logic signed [EDGE_W-1:0] edge_of(coord_t a, coord_t b);
		return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
	endfunction

	vertex_t v_q, anchor_q, second_q;
	logic    last_q;
	logic    seen_q, second_found_q, normal_found_q, out_valid_q;
	plane_t  plane_q;

	logic signed [EDGE_W-1:0] e1_q [NUM_AXES];
	logic signed [EDGE_W-1:0] e2_q [NUM_AXES];
	logic [PROD_W-1:0]        mula_q [NUM_AXES];
	logic [PROD_W-1:0]        mulb_q [NUM_AXES];
	logic signed [NORM_W-1:0] norm_q [NUM_AXES];
	logic [SQ_W-1:0]          sq_q [NUM_AXES];
	logic [QS_W-1:0]          qxy_q, qyz_q, qxz_q;

	logic signed [MUL_W-1:0]  mop_a [NUM_AXES];
	logic signed [MUL_W-1:0]  mop_b [NUM_AXES];
	logic signed [MULP_W-1:0] mprod [NUM_AXES];
	logic signed [NORM_W-1:0] diff [NUM_AXES];
	logic signed [NORM_W-1:0] norm_sel;
	logic [NORM_W-1:0]        norm_neg;
	logic [MAG_W-1:0]         mag;
	logic [HIGH_W-1:0]        mag_hi;
	logic [HALF_W-1:0]        mag_lo;
	logic [SQ_W-1:0]          sq_new;
	logic                     diff_nonzero;
	logic                     differs;
	logic                     out_free;
	logic                     emit;
	plane_t                   plane_best;

	assign differs  = (v_q != anchor_q);
	assign out_free = !out_valid_q || out_ready;
	assign emit     = (cmd.op == OP_EMIT_PLANE) || (cmd.op == OP_EMIT_DEGEN);

	// Magnitude of the selected normal component, split in halves for squaring.
	always_comb begin
		case (cmd.idx)
			2'd1:    norm_sel = norm_q[1];
			2'd2:    norm_sel = norm_q[2];
			default: norm_sel = norm_q[0];
		endcase
		norm_neg = -norm_sel;
		mag      = norm_sel[NORM_W-1] ? norm_neg[MAG_W-1:0] : norm_sel[MAG_W-1:0];
		mag_hi   = mag[MAG_W-1:HALF_W];
		mag_lo   = mag[HALF_W-1:0];
	end

	always_comb begin
		case (cmd.op)
			OP_CROSS_A: begin
				mop_a[0] = MUL_W'(e1_q[1]);
				mop_b[0] = MUL_W'(e2_q[2]);
				mop_a[1] = MUL_W'(e1_q[2]);
				mop_b[1] = MUL_W'(e2_q[0]);
				mop_a[2] = MUL_W'(e1_q[0]);
				mop_b[2] = MUL_W'(e2_q[1]);
			end
			OP_CROSS_B: begin
				mop_a[0] = MUL_W'(e1_q[2]);
				mop_b[0] = MUL_W'(e2_q[1]);
				mop_a[1] = MUL_W'(e1_q[0]);
				mop_b[1] = MUL_W'(e2_q[2]);
				mop_a[2] = MUL_W'(e1_q[1]);
				mop_b[2] = MUL_W'(e2_q[0]);
			end
			default: begin
				mop_a[0] = $signed(MUL_W'(mag_hi));
				mop_b[0] = $signed(MUL_W'(mag_hi));
				mop_a[1] = $signed(MUL_W'(mag_hi));
				mop_b[1] = $signed(MUL_W'(mag_lo));
				mop_a[2] = $signed(MUL_W'(mag_lo));
				mop_b[2] = $signed(MUL_W'(mag_lo));
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			mprod[i] = mop_a[i] * mop_b[i];
			diff[i]  = $signed({mula_q[i][PROD_W-1], mula_q[i]})
				- $signed({mulb_q[i][PROD_W-1], mulb_q[i]});
		end
		diff_nonzero = (diff[0] != '0) || (diff[1] != '0) || (diff[2] != '0);
	end

	// The cross term is doubled by shifting it one place further up.
	assign sq_new = (SQ_W'(mula_q[0]) << (2 * HALF_W))
		+ (SQ_W'(mula_q[1]) << (HALF_W + 1))
		+ SQ_W'(mula_q[2]);

	always_comb begin
		if (qxy_q <= qyz_q && qxy_q <= qxz_q) begin
			plane_best = PLANE_XY;
		end else if (qyz_q <= qxz_q) begin
			plane_best = PLANE_YZ;
		end else begin
			plane_best = PLANE_XZ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q         <= 1'b0;
			second_found_q <= 1'b0;
			normal_found_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_EVAL: begin
					if (!seen_q) begin
						seen_q <= 1'b1;
					end else if (!second_found_q && differs) begin
						second_found_q <= 1'b1;
					end
				end
				OP_CROSS_C: begin
					if (diff_nonzero) begin
						normal_found_q <= 1'b1;
					end
				end
				OP_EMIT_PLANE, OP_EMIT_DEGEN: begin
					seen_q         <= 1'b0;
					second_found_q <= 1'b0;
					normal_found_q <= 1'b0;
					out_valid_q    <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				v_q    <= '{x: vertex_x, y: vertex_y, z: vertex_z};
				last_q <= last_vertex;
			end
			OP_EVAL: begin
				if (!seen_q) begin
					anchor_q <= v_q;
				end else if (!second_found_q && differs) begin
					second_q <= v_q;
				end
				e1_q[0] <= edge_of(second_q.x, anchor_q.x);
				e1_q[1] <= edge_of(second_q.y, anchor_q.y);
				e1_q[2] <= edge_of(second_q.z, anchor_q.z);
				e2_q[0] <= edge_of(v_q.x, anchor_q.x);
				e2_q[1] <= edge_of(v_q.y, anchor_q.y);
				e2_q[2] <= edge_of(v_q.z, anchor_q.z);
			end
			OP_CROSS_A, OP_SQ_MUL: begin
				for (int i = 0; i < NUM_AXES; i++) begin
					mula_q[i] <= mprod[i][PROD_W-1:0];
				end
			end
			OP_CROSS_B: begin
				for (int i = 0; i < NUM_AXES; i++) begin
					mulb_q[i] <= mprod[i][PROD_W-1:0];
				end
			end
			OP_CROSS_C: begin
				if (diff_nonzero) begin
					for (int i = 0; i < NUM_AXES; i++) begin
						norm_q[i] <= diff[i];
					end
				end
			end
			OP_SQ_ACC: begin
				for (int i = 0; i < NUM_AXES; i++) begin
					if (cmd.idx == 2'(i)) begin
						sq_q[i] <= sq_new;
					end
				end
			end
			OP_SUM: begin
				qxy_q <= QS_W'(sq_q[0]) + QS_W'(sq_q[1]);
				qyz_q <= QS_W'(sq_q[1]) + QS_W'(sq_q[2]);
				qxz_q <= QS_W'(sq_q[2]) + QS_W'(sq_q[0]);
			end
			OP_EMIT_PLANE: begin
				plane_q <= plane_best;
			end
			OP_EMIT_DEGEN: begin
				plane_q <= PLANE_NONE;
			end
			default: begin
			end
		endcase
	end

	assign sts.need_cross   = seen_q && second_found_q && !normal_found_q;
	assign sts.last         = last_q;
	assign sts.normal_found = normal_found_q;
	assign sts.out_free     = out_free;
	assign out_valid        = out_valid_q;
	assign plane_choice     = plane_q;

`ifndef SYNTH
	a_flag_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!normal_found_q || second_found_q) && (!second_found_q || seen_q))
		else $error("polygon progress flags out of order");

	a_normal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		normal_found_q |-> (norm_q[0] != '0) || (norm_q[1] != '0) || (norm_q[2] != '0))
		else $error("stored normal is zero");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwritten before it was taken");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !seen_q && out_valid_q)
		else $error("polygon state not cleared after result");
`endif

endmodule

/* rtl/polygon_projection_plane_select_unit.sv */
// A vertex is loaded, then evaluated; a vertex that is tested against the plane then goes
// through CROSS_A and CROSS_B, as the three shared multipliers form the cross product, and
// CROSS_C, where the difference is checked. A last vertex then passes DECIDE, and when a normal
// exists the three normal components are squared on the same multipliers before SUM and CMP.
// The result sits in an output register; the next vertex is taken while it waits.
// Reset (arst_n low, asynchronous) clears the polygon state and the result valid.
module polygon_projection_plane_select_unit (
	input  logic        clk,
	input  logic        arst_n,
	ppps_vertex_if.sink vertex,
	ppps_plane_if.source result
);
	import ppps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ppps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vertex.valid),
		.in_ready (vertex.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppps_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.vertex_x     (vertex.vertex_x),
		.vertex_y     (vertex.vertex_y),
		.vertex_z     (vertex.vertex_z),
		.last_vertex  (vertex.last_vertex),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.plane_choice (result.plane_choice)
	);

endmodule

/* sim/ppps_plane_checker.sv */
// Watches the vertex and plane channels of the projection plane select unit,
// predicts each plane choice from the accepted vertex words and compares it.
// Depends on ppps_pkg and the channel interfaces in ppps_ifs.
module ppps_plane_checker (
	input  logic   clk,
	input  logic   arst_n,
	ppps_vertex_if vertex_mon,
	ppps_plane_if  result_mon,
	output int     fail_count,
	output int     pending,
	output int     checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import ppps_pkg::*;

	// Wide enough for the sum of two squared normal components.
	typedef bit [QS_W:0] sumsq_t;

	longint anchor_pt[3];
	longint second_pt[3];
	longint normal_vec[3];
	logic   have_anchor;
	logic   have_second;
	logic   have_normal;
	plane_t expected_planes[$];

	function automatic void clear_polygon();
		for (int i = 0; i < 3; i++) begin
			anchor_pt[i]  = 0;
			second_pt[i]  = 0;
			normal_vec[i] = 0;
		end
		have_anchor = 1'b0;
		have_second = 1'b0;
		have_normal = 1'b0;
	endfunction

	function automatic sumsq_t square_mag(longint s);
		sumsq_t m;
		m = (s < 0) ? sumsq_t'(-s) : sumsq_t'(s);
		return m * m;
	endfunction

	function automatic plane_t best_plane();
		sumsq_t sx, sy, sz, qxy, qyz, qxz;
		sx  = square_mag(normal_vec[0]);
		sy  = square_mag(normal_vec[1]);
		sz  = square_mag(normal_vec[2]);
		qxy = sx + sy;
		qyz = sy + sz;
		qxz = sz + sx;
		if (qxy <= qyz && qxy <= qxz) begin
			return PLANE_XY;
		end
		if (qyz <= qxz) begin
			return PLANE_YZ;
		end
		return PLANE_XZ;
	endfunction

	function automatic void absorb_vertex(longint vx, longint vy, longint vz, logic last);
		longint p[3], e1[3], e2[3], n[3];
		plane_t plane_next;
		p[0] = vx;
		p[1] = vy;
		p[2] = vz;
		if (!have_anchor) begin
			anchor_pt   = p;
			have_anchor = 1'b1;
		end else if (!have_second) begin
			// A repeat of the anchor does not count as the second vertex.
			if (p != anchor_pt) begin
				second_pt   = p;
				have_second = 1'b1;
			end
		end else if (!have_normal) begin
			for (int i = 0; i < 3; i++) begin
				e1[i] = second_pt[i] - anchor_pt[i];
				e2[i] = p[i] - anchor_pt[i];
			end
			n[0] = e1[1] * e2[2] - e1[2] * e2[1];
			n[1] = e1[2] * e2[0] - e1[0] * e2[2];
			n[2] = e1[0] * e2[1] - e1[1] * e2[0];
			if (n[0] != 0 || n[1] != 0 || n[2] != 0) begin
				normal_vec  = n;
				have_normal = 1'b1;
			end
		end
		if (last) begin
			plane_next      = have_normal ? best_plane() : PLANE_NONE;
			expected_planes = {expected_planes, plane_next};
			clear_polygon();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		plane_t oldest;
		if (!arst_n) begin
			clear_polygon();
			expected_planes.delete();
			fail_count = 0;
			checked    = 0;
			pending    = 0;
		end else begin
			// The result side goes first so that a word never meets an expectation
			// queued at the same edge.
			if (result_mon.valid && result_mon.ready) begin
				if (expected_planes.size() == 0) begin
					$error("plane_choice: expected none, actual %0d", result_mon.plane_choice);
					fail_count++;
				end else begin
					oldest = expected_planes.pop_front();
					if (result_mon.plane_choice !== oldest) begin
						$error("plane_choice: expected %0d, actual %0d", oldest,
							result_mon.plane_choice);
						fail_count++;
					end
					checked++;
				end
			end
			if (vertex_mon.valid && vertex_mon.ready) begin
				absorb_vertex(longint'($signed(vertex_mon.vertex_x)),
					longint'($signed(vertex_mon.vertex_y)),
					longint'($signed(vertex_mon.vertex_z)), vertex_mon.last_vertex);
			end
			pending = expected_planes.size();
		end
	end

endmodule

/* sim/tb.sv */
// Top of the testbench: clock, reset, vertex stimulus and result back-pressure
// around polygon_projection_plane_select_unit; the verdict comes from ppps_plane_checker.
// Depends on ppps_pkg, ppps_ifs and the unit itself.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppps_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	int fail_count;
	int planes_pending;
	int planes_checked;

	int send_idle_pct;
	int stall_pct;
	int hold_request;
	int hold_left;
	int vertices_sent;
	int polygons_sent;

	vertex_t poly_buf[$];

	ppps_vertex_if vertex_ch();
	ppps_plane_if  result_ch();

	polygon_projection_plane_select_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex_ch),
		.result (result_ch)
	);

	ppps_plane_checker plane_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.vertex_mon (vertex_ch),
		.result_mon (result_ch),
		.fail_count (fail_count),
		.pending    (planes_pending),
		.checked    (planes_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// Result back-pressure; a long hold-off is counted out here once requested.
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic coord_t rand_coord(int lo, int hi);
		return coord_t'(int'($urandom_range(hi - lo)) + lo);
	endfunction

	function automatic void append_pt(vertex_t p);
		poly_buf = {poly_buf, p};
	endfunction

	function automatic void add_pt(int x, int y, int z);
		vertex_t p;
		p.x = coord_t'(x);
		p.y = coord_t'(y);
		p.z = coord_t'(z);
		append_pt(p);
	endfunction

	task automatic send_vertex(input vertex_t p, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			vertex_ch.valid <= 1'b0;
			@(negedge clk);
		end
		vertex_ch.valid       <= 1'b1;
		vertex_ch.vertex_x    <= p.x;
		vertex_ch.vertex_y    <= p.y;
		vertex_ch.vertex_z    <= p.z;
		vertex_ch.last_vertex <= last;
		do @(posedge clk); while (!vertex_ch.ready);
		vertices_sent++;
	endtask

	task automatic send_polygon();
		for (int i = 0; i < poly_buf.size(); i++) begin
			send_vertex(poly_buf[i], i == poly_buf.size() - 1);
		end
		polygons_sent++;
		poly_buf.delete();
	endtask

	function automatic void make_polygon();
		int      style, count, axis, k;
		vertex_t a, d, p;
		style = $urandom_range(99);
		count = $urandom_range(3, 7);
		if (style < 45) begin
			for (int i = 0; i < count; i++) begin
				add_pt(rand_coord(-32768, 32767), rand_coord(-32768, 32767),
					rand_coord(-32768, 32767));
			end
		end else if (style < 65) begin
			// Tiny coordinates give many ties, repeats and collinear runs.
			for (int i = 0; i < count; i++) begin
				add_pt(rand_coord(-3, 3), rand_coord(-3, 3), rand_coord(-3, 3));
			end
		end else if (style < 80) begin
			// Polygon flat on one axis plane, so the normal lies along that axis.
			axis = $urandom_range(2);
			k    = rand_coord(-32768, 32767);
			for (int i = 0; i < count; i++) begin
				p.x = (axis == 0) ? coord_t'(k) : rand_coord(-32768, 32767);
				p.y = (axis == 1) ? coord_t'(k) : rand_coord(-32768, 32767);
				p.z = (axis == 2) ? coord_t'(k) : rand_coord(-32768, 32767);
				append_pt(p);
			end
		end else if (style < 92) begin
			// Anchor, optional repeats of it, then points on the first edge's line and up to two random points.
			a.x = rand_coord(-10000, 10000);
			a.y = rand_coord(-10000, 10000);
			a.z = rand_coord(-10000, 10000);
			d.x = rand_coord(-100, 100);
			d.y = rand_coord(-100, 100);
			d.z = rand_coord(-100, 100);
			append_pt(a);
			repeat ($urandom_range(2)) append_pt(a);
			for (k = 1; k <= $urandom_range(1, 4); k++) begin
				add_pt(a.x + k * d.x, a.y + k * d.y, a.z + k * d.z);
			end
			repeat ($urandom_range(2)) begin
				add_pt(rand_coord(-32768, 32767), rand_coord(-32768, 32767),
					rand_coord(-32768, 32767));
			end
		end else begin
			// Short polygons, or polygons with repeats of one vertex.
			a.x = rand_coord(-32768, 32767);
			a.y = rand_coord(-32768, 32767);
			a.z = rand_coord(-32768, 32767);
			count = ($urandom_range(1) == 0) ? $urandom_range(1, 2) : count;
			for (int i = 0; i < count; i++) begin
				if (i > 0 && $urandom_range(1) == 0) begin
					append_pt(a);
				end else begin
					add_pt(rand_coord(-32768, 32767), rand_coord(-32768, 32767),
						rand_coord(-32768, 32767));
				end
			end
		end
	endfunction

	initial begin
		int target;
		arst_n                = 1'b0;
		vertex_ch.valid       = 1'b0;
		vertex_ch.vertex_x    = '0;
		vertex_ch.vertex_y    = '0;
		vertex_ch.vertex_z    = '0;
		vertex_ch.last_vertex = 1'b0;
		send_idle_pct         = 0;
		stall_pct             = 0;
		hold_request          = 0;
		vertices_sent         = 0;
		polygons_sent         = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single vertex, then two extreme vertices: both degenerate. Then three extreme corners.
		add_pt(0, 0, 0);
		send_polygon();
		add_pt(-32768, -32768, -32768);
		add_pt(32767, 32767, 32767);
		send_polygon();
		add_pt(-32768, -32768, -32768);
		add_pt(32767, 32767, -32768);
		add_pt(32767, -32768, 32767);
		send_polygon();
		// Normal along z, x and y in turn.
		add_pt(0, 0, 0); add_pt(1, 0, 0); add_pt(0, 1, 0);
		send_polygon();
		add_pt(0, 0, 0); add_pt(0, 1, 0); add_pt(0, 0, 1);
		send_polygon();
		add_pt(0, 0, 0); add_pt(0, 0, 1); add_pt(1, 0, 0);
		send_polygon();
		// Three-way tie resolves to XY; YZ against XZ tie resolves to YZ.
		add_pt(0, 0, 0); add_pt(1, -1, 0); add_pt(0, 1, -1);
		send_polygon();
		add_pt(0, 0, 0); add_pt(0, 0, 1); add_pt(1, -1, 0);
		send_polygon();
		// Anchor repeat, a collinear vertex, the normal, then an ignored vertex.
		add_pt(5, 5, 5); add_pt(5, 5, 5); add_pt(6, 7, 8);
		add_pt(7, 9, 11); add_pt(0, 0, 0); add_pt(100, -3, 7);
		send_polygon();
		add_pt(3, 3, 3); add_pt(3, 3, 3); add_pt(3, 3, 3);
		send_polygon();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  hold_request = 300; end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 21; stall_pct = 21; end
			endcase
			target = vertices_sent + 450;
			while (vertices_sent < target) begin
				make_polygon();
				send_polygon();
			end
		end

		@(negedge clk);
		vertex_ch.valid <= 1'b0;
		wait (planes_pending == 0);
		repeat (20) @(posedge clk);
		$display("Run covered %0d vertex words in %0d polygons over four idle/stall phases,",
			vertices_sent, polygons_sent);
		$display("including one long result hold-off; %0d plane words compared, %0d failures.",
			planes_checked, fail_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
